>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helper functions of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // region and block geometry
   localparam int MAX_ORDER       = 16;
   localparam int MIN_BLOCK_ORDER = 3;
   localparam int IDX_W      = MAX_ORDER - MIN_BLOCK_ORDER; // block number bits
   localparam int NUM_BLOCKS = 1 << IDX_W;
   localparam int NUM_LISTS  = MAX_ORDER - MIN_BLOCK_ORDER;
   localparam int LINK_W     = IDX_W + 1;                   // valid bit above index
   localparam int LI_W       = $clog2(NUM_LISTS);
   localparam int ADDR_W     = 16;
   localparam int SIZE_W     = 17;
   localparam int ORD_W      = 5;
   localparam int STEP_W     = IDX_W + 1;

   typedef logic [LINK_W-1:0] link_type;

   // operation codes
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_ADD   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_BLOCK  = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC_POP,
      S_ALLOC_SPLIT,
      S_FREE_START,
      S_FREE_CHECK,
      S_FREE_EVAL,
      S_FREE_TAIL,
      S_ADD_PUSH,
      S_FINISH
   } state_type;

   // smallest order whose block holds size, never below the minimum
   function automatic logic [ORD_W-1:0] order_of(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m;
      logic [ORD_W-1:0]  k;
      m = size - SIZE_W'(1);
      k = ORD_W'(MIN_BLOCK_ORDER);
      if (size > SIZE_W'(1 << MIN_BLOCK_ORDER)) begin
         for (int i = 0; i < SIZE_W; i++) begin
            if (m[i]) k = ORD_W'(i + 1);
         end
      end
      return k;
   endfunction

   // index of the highest set bit
   function automatic logic [ORD_W-1:0] msb_of(input logic [SIZE_W-1:0] v);
      logic [ORD_W-1:0] k;
      k = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (v[i]) k = ORD_W'(i);
      end
      return k;
   endfunction

   // index of the lowest set bit, MAX_ORDER when zero
   function automatic logic [ORD_W-1:0] lsb_of(input logic [ADDR_W-1:0] v);
      logic [ORD_W-1:0] k;
      k = ORD_W'(MAX_ORDER);
      for (int i = ADDR_W - 1; i >= 0; i--) begin
         if (v[i]) k = ORD_W'(i);
      end
      return k;
   endfunction

endpackage

`default_nettype wire

>>> sv/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 64 KiB region with 8-byte minimum blocks.
// ----------------------------------------------------------------------------
// One item at a time. Each order keeps a singly linked free list: heads in
// flip-flops, next links in an 8192 x 14 RAM with a registered read.
// Allocate pops a head, then pushes one split half per order; free climbs
// one order per merge, walks each list with a check and an evaluate step per
// element, and may append at the tail; add range pushes one block at a time
// until it sees the range is done. Every item also passes acceptance, decode
// and result hand-off, the hand-off waiting while the previous result is still
// held. The next-link RAM port sets the pace of list walks.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   // request item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [15:0] address, [32:16] size_bytes, zero pad
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   // response item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] block_address
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   import bba_pkg::*;

   // registers
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ORD_W-1:0]    kord_ff, kord_in;
   logic [ORD_W-1:0]    j_ff, j_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic [SIZE_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   end_ff, end_in;
   link_type            cur_ff, cur_in;
   link_type            prev_ff, prev_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   status_type          res_st_ff, res_st_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_st_ff, rsp_st_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   link_type            heads_ff [NUM_LISTS];

   // list head port
   logic                hd_we;
   logic [LI_W-1:0]     hd_wi;
   link_type            hd_wd;
   logic [LI_W-1:0]     hd_ri;
   link_type            hd_rd;

   // next-link RAM port
   logic                ram_we, ram_re;
   logic [IDX_W-1:0]    ram_wa, ram_ra;
   link_type            ram_wd, ram_rd;

   bba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_links (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign hd_rd      = heads_ff[hd_ri];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_st_ff;

   // control, sequencing and datapath
   always_comb begin
      logic [ORD_W-1:0]  k;
      logic [ORD_W-1:0]  o;
      logic              found;
      logic [ORD_W-1:0]  jm;
      logic [IDX_W-1:0]  cb;
      logic [IDX_W-1:0]  me;
      logic [ADDR_W-1:0] buddy;
      logic              match;
      logic [SIZE_W-1:0] rem;
      logic [SIZE_W:0]   sum;
      logic [ORD_W-1:0]  ka;
      logic [ORD_W-1:0]  kt;

      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      kord_in      = kord_ff;
      j_in         = j_ff;
      off_in       = off_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      res_st_in    = res_st_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_addr_in  = rsp_addr_ff;

      hd_we  = 1'b0;
      hd_wi  = '0;
      hd_wd  = '0;
      hd_ri  = LI_W'(kord_ff - ORD_W'(MIN_BLOCK_ORDER));
      ram_we = 1'b0;
      ram_wa = '0;
      ram_wd = '0;
      ram_re = 1'b0;
      ram_ra = cur_ff[IDX_W-1:0];

      k     = order_of(size_ff);
      o     = k;
      found = 1'b0;
      for (int i = NUM_LISTS - 1; i >= 0; i--) begin
         if (heads_ff[i][IDX_W] && ORD_W'(i + MIN_BLOCK_ORDER) >= k) begin
            o     = ORD_W'(i + MIN_BLOCK_ORDER);
            found = 1'b1;
         end
      end
      jm    = j_ff - ORD_W'(1);
      cb    = cur_ff[IDX_W-1:0];
      me    = off_ff[ADDR_W-1:MIN_BLOCK_ORDER];
      buddy = off_ff ^ (ADDR_W'(1) << kord_ff);
      match = (kord_ff + ORD_W'(1) < ORD_W'(MAX_ORDER)) &&
              ({cb, MIN_BLOCK_ORDER'(0)} == buddy);
      rem   = end_ff - base_ff;
      sum   = (SIZE_W+1)'(addr_ff) + (SIZE_W+1)'(size_ff);
      ka    = msb_of(rem);
      kt    = lsb_of(base_ff[ADDR_W-1:0]);
      if (kt < ka) ka = kt;
      if (ka > ORD_W'(MAX_ORDER - 1)) ka = ORD_W'(MAX_ORDER - 1);

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = op_type'(req_tuser);
               addr_in     = {req_tdata[15:MIN_BLOCK_ORDER], MIN_BLOCK_ORDER'(0)};
               size_in     = req_tdata[32:16];
               res_st_in   = ST_OK;
               res_addr_in = '0;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            kord_in = k;
            case (op_ff)
               OP_ALLOC: begin
                  if (k >= ORD_W'(MAX_ORDER)) begin
                     res_st_in = ST_TOO_LARGE;
                     state_in  = S_FINISH;
                  end else if (!found) begin
                     res_st_in = ST_NO_BLOCK;
                     state_in  = S_FINISH;
                  end else begin
                     // fetch the successor of the popped head
                     hd_ri    = LI_W'(o - ORD_W'(MIN_BLOCK_ORDER));
                     j_in     = o;
                     off_in   = {hd_rd[IDX_W-1:0], MIN_BLOCK_ORDER'(0)};
                     ram_re   = 1'b1;
                     ram_ra   = hd_rd[IDX_W-1:0];
                     state_in = S_ALLOC_POP;
                  end
               end
               OP_FREE: begin
                  if (k >= ORD_W'(MAX_ORDER)) begin
                     res_st_in = ST_TOO_LARGE;
                     state_in  = S_FINISH;
                  end else begin
                     off_in   = addr_ff & ~((ADDR_W'(1) << k) - ADDR_W'(1));
                     state_in = S_FREE_START;
                  end
               end
               OP_ADD: begin
                  base_in = SIZE_W'(addr_ff);
                  end_in  = (sum > (SIZE_W+1)'(1 << MAX_ORDER)) ?
                            SIZE_W'(1 << MAX_ORDER) : sum[SIZE_W-1:0];
                  state_in = S_ADD_PUSH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_ALLOC_POP: begin
            hd_we       = 1'b1;
            hd_wi       = LI_W'(j_ff - ORD_W'(MIN_BLOCK_ORDER));
            hd_wd       = ram_rd;
            res_addr_in = off_ff;
            state_in    = (j_ff == kord_ff) ? S_FINISH : S_ALLOC_SPLIT;
         end
         S_ALLOC_SPLIT: begin
            // push the upper half left over at order j-1
            hd_ri  = LI_W'(jm - ORD_W'(MIN_BLOCK_ORDER));
            ram_we = 1'b1;
            ram_wa = me + (IDX_W'(1) << (jm - ORD_W'(MIN_BLOCK_ORDER)));
            ram_wd = hd_rd;
            hd_we  = 1'b1;
            hd_wi  = hd_ri;
            hd_wd  = {1'b1, ram_wa};
            j_in   = jm;
            if (jm == kord_ff) state_in = S_FINISH;
         end
         S_FREE_START: begin
            if (!hd_rd[IDX_W]) begin
               ram_we   = 1'b1;
               ram_wa   = me;
               ram_wd   = hd_rd;
               hd_we    = 1'b1;
               hd_wi    = hd_ri;
               hd_wd    = {1'b1, me};
               state_in = S_FINISH;
            end else begin
               cur_in   = hd_rd;
               prev_in  = '0;
               steps_in = '0;
               state_in = S_FREE_CHECK;
            end
         end
         S_FREE_CHECK: begin
            if (steps_ff >= STEP_W'(NUM_BLOCKS)) begin
               // corrupted list: push at the head
               ram_we   = 1'b1;
               ram_wa   = me;
               ram_wd   = hd_rd;
               hd_we    = 1'b1;
               hd_wi    = hd_ri;
               hd_wd    = {1'b1, me};
               state_in = S_FINISH;
            end else begin
               steps_in = steps_ff + STEP_W'(1);
               ram_re   = 1'b1;
               state_in = S_FREE_EVAL;
            end
         end
         S_FREE_EVAL: begin
            if (match) begin
               // unlink the buddy and merge one order up
               if (prev_ff[IDX_W]) begin
                  ram_we = 1'b1;
                  ram_wa = prev_ff[IDX_W-1:0];
                  ram_wd = ram_rd;
               end else begin
                  hd_we = 1'b1;
                  hd_wi = hd_ri;
                  hd_wd = ram_rd;
               end
               off_in   = off_ff & ~(ADDR_W'(1) << kord_ff);
               kord_in  = kord_ff + ORD_W'(1);
               state_in = S_FREE_START;
            end else if (!ram_rd[IDX_W]) begin
               ram_we   = 1'b1;
               ram_wa   = cb;
               ram_wd   = {1'b1, me};
               state_in = S_FREE_TAIL;
            end else begin
               prev_in  = cur_ff;
               cur_in   = ram_rd;
               state_in = S_FREE_CHECK;
            end
         end
         S_FREE_TAIL: begin
            ram_we   = 1'b1;
            ram_wa   = me;
            ram_wd   = '0;
            state_in = S_FINISH;
         end
         S_ADD_PUSH: begin
            if (base_ff < end_ff && rem >= SIZE_W'(1 << MIN_BLOCK_ORDER)) begin
               hd_ri   = LI_W'(ka - ORD_W'(MIN_BLOCK_ORDER));
               ram_we  = 1'b1;
               ram_wa  = base_ff[ADDR_W-1:MIN_BLOCK_ORDER];
               ram_wd  = hd_rd;
               hd_we   = 1'b1;
               hd_wi   = hd_ri;
               hd_wd   = {1'b1, ram_wa};
               base_in = base_ff + (SIZE_W'(1) << ka);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_addr_in  = res_addr_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) heads_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (hd_we) heads_ff[hd_wi] <= hd_wd;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      kord_ff     <= kord_in;
      j_ff        <= j_in;
      off_ff      <= off_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   // checks
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re && ram_wa == ram_ra))
      else $error("link read and write hit one entry in one cycle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_EVAL) |-> (steps_ff <= STEP_W'(NUM_BLOCKS)))
      else $error("list walk overran its step bound");

endmodule

`default_nettype wire

>>> test/tb_buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench for the buddy block allocator.
// ----------------------------------------------------------------------------
// Requests are driven with random gaps, none in gapless runs. Each accepted
// request runs through a local model of the free lists, its prediction queued.
// Responses get random stalls, none if gapless, and are checked in order. Test tasks
// cover edge cases, a long response hold-off and random alloc/free traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_buddy_block_allocator;
   import bba_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      status_type  status;
      logic [15:0] block_address;
   } alloc_result_type;

   typedef struct {
      int unsigned addr;
      int unsigned ord;
   } live_block_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // [15:0] address, [32:16] size_bytes, zero pad
   logic [1:0]  req_tuser = '0;     // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] block_address
   logic [1:0]  rsp_tuser;          // [1:0] status

   // free list mirror: valid bit above block number
   int unsigned      mirror_heads[NUM_LISTS];
   int unsigned      mirror_links[NUM_BLOCKS];
   alloc_result_type pending_results[$];
   live_block_type   live_blocks[$];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  allocs_ok     = 0;
   int  rsp_stall     = 0;
   int  hold_count    = 0;
   int  idle_cycles   = 0;
   bit  no_gaps       = 1'b0;
   bit  hold_request  = 1'b0;

   buddy_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // free list mirror
   // ---------------------------------------------------------------------
   function automatic int unsigned round_order(longint unsigned size);
      int unsigned k;
      k = MIN_BLOCK_ORDER;
      while (k < 63 && (64'd1 << k) < size) k++;
      return k;
   endfunction

   function automatic void push_block(int unsigned k, longint unsigned off);
      int unsigned b;
      b = int'((off >> MIN_BLOCK_ORDER) & (NUM_BLOCKS - 1));
      mirror_links[b] = mirror_heads[k - MIN_BLOCK_ORDER];
      mirror_heads[k - MIN_BLOCK_ORDER] = NUM_BLOCKS | b;
   endfunction

   function automatic void release_block(int unsigned k_in, longint unsigned off_in);
      int unsigned     k, li, me, cur, prev, cb, steps;
      longint unsigned off, buddy;
      bit              can_merge, merged;
      k   = k_in;
      off = off_in;
      forever begin
         li        = k - MIN_BLOCK_ORDER;
         me        = int'((off >> MIN_BLOCK_ORDER) & (NUM_BLOCKS - 1));
         cur       = mirror_heads[li];
         prev      = 0;
         buddy     = off ^ (64'd1 << k);
         can_merge = (k + 1 < MAX_ORDER);
         merged    = 1'b0;
         steps     = 0;
         if ((cur & NUM_BLOCKS) == 0) begin
            push_block(k, off);
            return;
         end
         forever begin
            cb = cur & (NUM_BLOCKS - 1);
            if (steps >= NUM_BLOCKS) begin
               // walk ran away on a broken list
               push_block(k, off);
               return;
            end
            steps++;
            if (can_merge && (longint'(cb) << MIN_BLOCK_ORDER) == buddy) begin
               if (prev & NUM_BLOCKS)
                  mirror_links[prev & (NUM_BLOCKS - 1)] = mirror_links[cb];
               else
                  mirror_heads[li] = mirror_links[cb];
               merged = 1'b1;
               break;
            end
            if ((mirror_links[cb] & NUM_BLOCKS) == 0) begin
               mirror_links[cb] = NUM_BLOCKS | me;
               mirror_links[me] = 0;
               return;
            end
            prev = cur;
            cur  = mirror_links[cb];
         end
         if (!merged) return;
         if (buddy < off) off = buddy;
         k++;
      end
   endfunction

   function automatic void add_free_range(longint unsigned base_in, longint unsigned size);
      longint unsigned base, stop, rem;
      int unsigned     k;
      base = base_in;
      stop = base + size;
      if (stop > (64'd1 << MAX_ORDER)) stop = 64'd1 << MAX_ORDER;
      while (base < stop && stop - base >= (64'd1 << MIN_BLOCK_ORDER)) begin
         rem = stop - base;
         k   = MAX_ORDER - 1;
         while (k > MIN_BLOCK_ORDER &&
                ((64'd1 << k) > rem || (base & ((64'd1 << k) - 1)) != 0))
            k--;
         push_block(k, base);
         base += 64'd1 << k;
      end
   endfunction

   // one request through the mirror, giving its response
   function automatic alloc_result_type predict_request(op_type op, logic [15:0] address,
                                                        logic [16:0] size_bytes);
      alloc_result_type r;
      longint unsigned  addr, off;
      int unsigned      k, o, h;
      live_block_type   lb;
      r.status        = ST_OK;
      r.block_address = '0;
      addr = longint'(address) & ~64'd7;
      case (op)
         OP_ALLOC: begin
            k = round_order(size_bytes);
            if (k >= MAX_ORDER) begin
               r.status = ST_TOO_LARGE;
            end else begin
               o = k;
               while (o < MAX_ORDER &&
                      (mirror_heads[o - MIN_BLOCK_ORDER] & NUM_BLOCKS) == 0) o++;
               if (o >= MAX_ORDER) begin
                  r.status = ST_NO_BLOCK;
               end else begin
                  h   = mirror_heads[o - MIN_BLOCK_ORDER];
                  off = longint'(h & (NUM_BLOCKS - 1)) << MIN_BLOCK_ORDER;
                  mirror_heads[o - MIN_BLOCK_ORDER] = mirror_links[h & (NUM_BLOCKS - 1)];
                  for (int unsigned j = o; j > k; j--)
                     push_block(j - 1, off + (64'd1 << (j - 1)));
                  r.block_address = off[15:0];
                  lb.addr = int'(off);
                  lb.ord  = k;
                  live_blocks.push_back(lb);
                  allocs_ok++;
               end
            end
         end
         OP_FREE: begin
            k = round_order(size_bytes);
            if (k >= MAX_ORDER) r.status = ST_TOO_LARGE;
            else release_block(k, addr & ~((64'd1 << k) - 1));
         end
         OP_ADD:  add_free_range(addr, size_bytes);
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   task automatic send_item(op_type op, logic [15:0] address, logic [16:0] size_bytes);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, size_bytes, address};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_request(op, address, size_bytes));
      items_sent++;
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // free one live block with a size that rounds back to its order
   task automatic free_live_block();
      int             idx;
      live_block_type lb;
      logic [16:0]    sz;
      idx = $urandom_range(0, live_blocks.size() - 1);
      lb  = live_blocks[idx];
      live_blocks.delete(idx);
      if (lb.ord == MIN_BLOCK_ORDER) sz = 17'($urandom_range(0, 8));
      else sz = 17'($urandom_range((1 << (lb.ord - 1)) + 1, 1 << lb.ord));
      send_item(OP_FREE, 16'(lb.addr), sz);
   endtask

   // ---------------------------------------------------------------------
   // response side: stalls, long hold-off, checking
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request) begin
         hold_count   = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_count > 0) begin
         rsp_tready <= 1'b0;
         hold_count--;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         rsp_stall = no_gaps ? 0 : $urandom_range(0, 9);
         if (pending_results.size() == 0) begin
            error_count++;
            $error("unexpected response: status %0d block_address 0x%04h",
                   rsp_tuser, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               error_count++;
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
            end
            if (rsp_tdata !== want.block_address) begin
               error_count++;
               $error("block_address: expected 0x%04h, got 0x%04h",
                      want.block_address, rsp_tdata);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without progress", idle_cycles);
         $display("[buddy_block_allocator] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_edge_cases();
      send_item(OP_ALLOC, 16'h0000, 17'd8);          // every list empty
      send_item(OP_ALLOC, 16'h0000, 17'h1FFFF);      // too large
      send_item(OP_FREE,  16'hFFFF, 17'h10000);      // too large free
      send_item(OP_NONE,  16'hFFFF, 17'h1FFFF);      // unknown op
      send_item(OP_ADD,   16'h0000, 17'h10000);      // whole region
      send_item(OP_ALLOC, 16'hFFFF, 17'd0);          // size zero rounds to minimum
      send_item(OP_ALLOC, 16'h0000, 17'd1);
      send_item(OP_ALLOC, 16'h0000, 17'd9);
      send_item(OP_ALLOC, 16'h0000, 17'h8000);       // top order block
      send_item(OP_ALLOC, 16'h0000, 17'h8000);       // none left at top order
      send_item(OP_FREE,  16'h8123, 17'h8000);       // unaligned, top order never merged
      send_item(OP_FREE,  16'h0007, 17'd3);          // low bits ignored
      send_item(OP_FREE,  16'h001F, 17'd16);
      send_item(OP_ALLOC, 16'h0000, 17'd4096);
      send_item(OP_FREE,  16'h0000, 17'd4096);       // merges back up
      send_item(OP_ALLOC, 16'h0000, 17'd8);
      send_item(OP_FREE,  16'h0000, 17'd8);
      send_item(OP_ADD,   16'hFFF8, 17'h1FFFF);      // clipped at the region end
      send_item(OP_ADD,   16'h7FFD, 17'd7);          // remainder below minimum
      send_item(OP_ADD,   16'h0008, 17'd200);        // odd alignment split
      live_blocks.delete();
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) begin
         if (live_blocks.size() > 0 && $urandom_range(0, 1)) free_live_block();
         else send_item(OP_ALLOC, 16'($urandom), 17'($urandom_range(1, 256)));
      end
   endtask

   task automatic test_random_traffic(int count, bit gapless);
      int pick;
      no_gaps = gapless;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            send_item(OP_FREE, 16'($urandom), 17'($urandom));
         else if (pick < 5)
            send_item(OP_ADD, 16'($urandom), 17'($urandom));
         else if (pick < 7)
            send_item(op_type'($urandom_range(0, 3)), 16'($urandom), 17'($urandom));
         else if (pick < 52 || live_blocks.size() == 0)
            send_item(OP_ALLOC, 16'($urandom),
                      $urandom_range(0, 9) == 0 ? 17'($urandom_range(0, 17'h10000))
                                                : 17'($urandom_range(1, 1024)));
         else
            free_live_block();
      end
      no_gaps = 1'b0;
   endtask

   // return everything still held, so the region coalesces
   task automatic test_drain();
      while (live_blocks.size() > 0) free_live_block();
      send_item(OP_ALLOC, 16'h0000, 17'h8000);
   endtask

   initial begin
      foreach (mirror_heads[i]) mirror_heads[i] = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_edge_cases();
      test_backpressure();
      test_random_traffic(350, 1'b0);
      test_random_traffic(200, 1'b1);
      test_drain();
      end_requests();

      wait (pending_results.size() == 0);
      repeat (100) @(posedge clock);

      $display("covered %0d requests, %0d responses, %0d successful allocations",
               items_sent, results_seen, allocs_ok);
      $display("edge cases, a %0d-cycle response hold-off and gapped and gapless traffic",
               HOLD_CYCLES);
      if (error_count == 0 && pending_results.size() == 0)
         $display("[buddy_block_allocator] OK");
      else
         $display("[buddy_block_allocator] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
